### hdl/fir_pkg.sv
// Shared types and constants for the Q2.14 FIR filter.
package fir_pkg;

	localparam int TAPS_DEF   = 32;
	localparam int SAMPLE_W   = 16;
	localparam int COEF_W     = 16;
	localparam int COEF_IDX_W = 5;
	localparam int ACTION_W   = 2;
	localparam int ACC_W      = 32;
	localparam int OUT_SHIFT  = 3 + 14;

	typedef enum logic [ACTION_W-1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_COEF   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// Control for the row of tap cells
	typedef struct packed {
		logic load;
		logic rotate;
		logic clear;
		logic coef_we;
	} cell_ctl_t;

endpackage

### hdl/fir_filter_q2_14_taps.sv
// Sample beat: RUN does one MAC per tap through fir_mac; DRAIN and HOLD lead to the result.
// A new beat waits until the last sum is loaded; the row rotates once past the MAC.
// Coefficient and clear beats give no result and leave the block idle.
// Reset (arst_n low) zeroes history, coefficients, accumulator and handshake state.
// The result register lets a new beat be taken while a result waits.
module fir_filter_q2_14_taps import fir_pkg::*; #(
	parameter int TAPS = TAPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic        [ACTION_W-1:0]   action,
	input  logic signed [SAMPLE_W-1:0]   sample_in,
	input  logic        [COEF_IDX_W-1:0] coef_index,
	input  logic signed [COEF_W-1:0]     coef_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [SAMPLE_W-1:0]   sample_out
);

	localparam int CNT_W = $clog2(TAPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	state_t                     state_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       accept;
	action_t                    act;
	cell_ctl_t                  ctl;
	logic                       start;
	logic                       mul_en;
	logic                       load_out;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-1:0]    acc_shr;

	logic signed [SAMPLE_W-1:0] hist [TAPS];
	logic signed [COEF_W-1:0]   coef [TAPS];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign act      = action_t'(action);

	// Decode the beat into cell and MAC control
	always_comb begin
		ctl     = '0;
		start   = 1'b0;
		if (accept) begin
			case (act)
				ACT_SAMPLE: begin
					ctl.load = 1'b1;
					start    = 1'b1;
				end
				ACT_COEF:  ctl.coef_we = 1'b1;
				ACT_CLEAR: ctl.clear   = 1'b1;
				default:   ctl         = '0;
			endcase
		end
		ctl.rotate = (state_q == ST_RUN);
	end

	assign mul_en = (state_q == ST_RUN);

	// Row of tap cells; cell 0 sits at the MAC
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		fir_cell #(
			.INDEX(k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sample_prev((k == 0) ? sample_in : hist[(k + TAPS - 1) % TAPS]),
			.sample_next(hist[(k + 1) % TAPS]),
			.coef_next  (coef[(k + 1) % TAPS]),
			.coef_index (coef_index),
			.coef_value (coef_value),
			.sample     (hist[k]),
			.coef       (coef[k])
		);
	end

	fir_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.mul_en(mul_en),
		.sample(hist[0]),
		.coef  (coef[0]),
		.acc   (acc)
	);

	assign acc_shr = acc >>> OUT_SHIFT;

	// Load the result register once the sum is done and the register is free
	assign load_out = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);

	// Sequence one sample through the row and hold the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			sample_out_q <= '0;
		end else begin
			if (load_out) begin
				out_valid_q  <= 1'b1;
				sample_out_q <= SAMPLE_W'(acc_shr);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TAPS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_HOLD;
				ST_HOLD: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;

endmodule

### hdl/fir_cell.sv
// One tap cell: holds one history sample and one coefficient.
module fir_cell import fir_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic signed [SAMPLE_W-1:0]   sample_prev,
	input  logic signed [SAMPLE_W-1:0]   sample_next,
	input  logic signed [COEF_W-1:0]     coef_next,
	input  logic        [COEF_IDX_W-1:0] coef_index,
	input  logic signed [COEF_W-1:0]     coef_value,
	output logic signed [SAMPLE_W-1:0]   sample,
	output logic signed [COEF_W-1:0]     coef
);

	logic signed [SAMPLE_W-1:0] hist_q;
	logic signed [COEF_W-1:0]   coef_q;
	logic                       hit;

	assign hit = (32'(coef_index) == 32'(INDEX));

	// Shift on a new sample, rotate during the sum, zero on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctl.clear) begin
			hist_q <= '0;
		end else if (ctl.load) begin
			hist_q <= sample_prev;
		end else if (ctl.rotate) begin
			hist_q <= sample_next;
		end
	end

	// Rotate with the history, take a write addressed to this tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (ctl.coef_we && hit) begin
			coef_q <= coef_value;
		end else if (ctl.rotate) begin
			coef_q <= coef_next;
		end
	end

	assign sample = hist_q;
	assign coef   = coef_q;

endmodule

### hdl/fir_mac.sv
// Multiply-accumulate unit fed from the head of the cell row.
module fir_mac import fir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       mul_en,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic signed [COEF_W-1:0]   coef,
	output logic signed [ACC_W-1:0]    acc
);

	logic signed [ACC_W-1:0] prod_s1;
	logic                    prod_vld_s1;
	logic signed [ACC_W-1:0] acc_q;

	// Register the product
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= ACC_W'(sample * coef);
		end
	end

	// Clear on start, add each registered product (wraps)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
		end else if (start) begin
			prod_vld_s1 <= 1'b0;
			acc_q       <= '0;
		end else begin
			prod_vld_s1 <= mul_en;
			if (prod_vld_s1) begin
				acc_q <= acc_q + prod_s1;
			end
		end
	end

	assign acc = acc_q;

endmodule

### tb/tb.sv
// Self-checking bench for the Q2.14 direct-form FIR filter with handshake idling and a stall burst.
`timescale 1ns / 1ps

module tb import fir_pkg::*; ();

	localparam int TAPS        = TAPS_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 200000;

	// Tap model: history ring, pointer, coefficients and the filtered samples still owed
	class fir_tap_model;
		logic signed [SAMPLE_W-1:0] hist [TAPS];
		logic signed [COEF_W-1:0]   coefs [TAPS];
		int                         wr_ptr;
		logic signed [SAMPLE_W-1:0] owed_samples [$];
		int                         mismatches;

		function new();
			foreach (hist[i]) begin
				hist[i]  = '0;
				coefs[i] = '0;
			end
			wr_ptr     = 0;
			mismatches = 0;
		endfunction

		// Apply one accepted input beat; a sample beat queues the filtered sample it produces
		function void take_beat(action_t act, logic signed [SAMPLE_W-1:0] smp,
				logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
			bit [ACC_W-1:0]          acc;
			logic signed [ACC_W-1:0] prod;
			logic signed [ACC_W-1:0] shifted;
			int                      k;
			case (act)
				ACT_COEF: begin
					if (idx < TAPS)
						coefs[idx] = val;
				end
				ACT_CLEAR: begin
					foreach (hist[i])
						hist[i] = '0;
					wr_ptr = 0;
				end
				ACT_SAMPLE: begin
					hist[wr_ptr] = smp;
					acc = '0;
					for (int j = 0; j < TAPS; j++) begin
						k    = (wr_ptr + TAPS - j) % TAPS;
						prod = hist[k] * coefs[j];
						acc  = acc + prod;
					end
					wr_ptr  = (wr_ptr + 1) % TAPS;
					shifted = $signed(acc) >>> OUT_SHIFT;
					owed_samples.push_back(shifted[SAMPLE_W-1:0]);
				end
				default: ;
			endcase
		endfunction

		// Compare one output beat with the oldest owed sample
		function void check_sample(logic signed [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;
			if (owed_samples.size() == 0) begin
				$display("%0t: sample_out mismatch, expected no beat, actual %0d",
					$time, got);
				mismatches++;
			end else begin
				want = owed_samples.pop_front();
				if (got !== want) begin
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
						$time, want, got);
					mismatches++;
				end
			end
		endfunction

		function int owed();
			return owed_samples.size();
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n     = 1'b0;
	logic                         in_valid   = 1'b0;
	logic                         in_stall;
	logic        [ACTION_W-1:0]   action     = '0;
	logic signed [SAMPLE_W-1:0]   sample_in  = '0;
	logic        [COEF_IDX_W-1:0] coef_index = '0;
	logic signed [COEF_W-1:0]     coef_value = '0;
	logic                         out_valid;
	logic                         out_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0]   sample_out;

	fir_tap_model taps_model;
	int           send_idle = 0;
	int           recv_idle = 0;
	bit           hold_req  = 1'b0;
	bit           hold_done = 1'b0;
	int           hold_left = 0;
	int           cycle_cnt = 0;

	fir_filter_q2_14_taps #(.TAPS(TAPS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.sample_in  (sample_in),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// Check output beats; stall at random, or hold off for a long stretch on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			taps_model.check_sample(sample_out);
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// Offer one input beat after random idle cycles and hold it until accepted
	task automatic send_beat(action_t act, logic signed [SAMPLE_W-1:0] smp,
			logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		sample_in  <= smp;
		coef_index <= idx;
		coef_value <= val;
		do
			@(posedge clk);
		while (in_stall);
		taps_model.take_beat(act, smp, idx, val);
	endtask

	// Change idle rates between edges with the input side quiet
	task automatic set_rates(int snd, int rcv);
		in_valid <= 1'b0;
		@(negedge clk);
		send_idle = snd;
		recv_idle = rcv;
		@(posedge clk);
	endtask

	// Full-range words half the time, with extremes and small values mixed in
	function automatic logic signed [15:0] rand_word();
		case ($urandom_range(5))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random();
		int      pick;
		action_t act;
		pick = $urandom_range(99);
		if (pick < 72)
			act = ACT_SAMPLE;
		else if (pick < 94)
			act = ACT_COEF;
		else if (pick < 98)
			act = ACT_CLEAR;
		else
			act = ACT_NONE;
		send_beat(act, rand_word(), COEF_IDX_W'($urandom), rand_word());
	endtask

	initial begin
		taps_model = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		set_rates(19, 69);

		// Directed: zero taps, extreme taps at both ends, extreme samples, unused code, clear
		send_beat(ACT_SAMPLE, 16'sh1234, 5'd0, 16'sh0000);
		send_beat(ACT_COEF,   16'sh0000, 5'd0, 16'sh4000);
		send_beat(ACT_COEF,   16'sh0000, 5'd31, 16'sh8000);
		send_beat(ACT_COEF,   16'sh0000, 5'd1, 16'sh7FFF);
		send_beat(ACT_SAMPLE, 16'sh7FFF, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'shFFFF, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'sh0001, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'sh0000, 5'd0, 16'sh0000);
		send_beat(ACT_NONE,   16'sh7FFF, 5'd31, 16'sh7FFF);
		send_beat(ACT_SAMPLE, 16'sh4000, 5'd0, 16'sh0000);
		send_beat(ACT_COEF,   16'sh0000, 5'd0, 16'sh7FFF);
		send_beat(ACT_COEF,   16'sh0000, 5'd31, 16'sh7FFF);
		send_beat(ACT_CLEAR,  16'sh7FFF, 5'd31, 16'sh7FFF);
		send_beat(ACT_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'sh8000, 5'd0, 16'sh0000);
		for (int i = 0; i < 32; i += 8)
			send_beat(ACT_SAMPLE, 16'sh7FFF, 5'd0, 16'sh0000);
		send_beat(ACT_CLEAR,  16'sh0000, 5'd0, 16'sh0000);
		send_beat(ACT_SAMPLE, 16'sh8001, 5'd0, 16'sh0000);

		// Random beats under both idle mixes
		repeat (180) send_random();
		set_rates(69, 19);
		repeat (180) send_random();
		set_rates(0, 0);

		// Drain, then hold off the output while samples keep coming to back up the input
		while (taps_model.owed() != 0)
			@(posedge clk);
		@(negedge clk);
		hold_req = 1'b1;
		@(posedge clk);
		repeat (24) send_beat(ACT_SAMPLE, rand_word(), COEF_IDX_W'($urandom), rand_word());
		repeat (160) send_random();
		in_valid <= 1'b0;

		// Wait for the last results plus the block's latency
		while (taps_model.owed() != 0)
			@(posedge clk);
		repeat (TAPS + 8) @(posedge clk);
		if (taps_model.mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

### filelist.f
hdl/fir_pkg.sv
hdl/fir_cell.sv
hdl/fir_mac.sv
hdl/fir_filter_q2_14_taps.sv
tb/tb.sv
